[hdl/assert_macros.svh]
// Assertion macros shared by the pad color parser RTL.
// Needs clk_i and rst_ni in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition that must never hold outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

[hdl/pcp_pkg.sv]
// Package for the pad color command parser: sizes, codes, characters and types.
// No dependencies.
package pcp_pkg;

  localparam int PADS        = 4;
  localparam int FIELD_CHARS = 7;
  localparam int MAX_OUT     = 4;
  localparam int PAD_W       = 2;
  localparam int CC_W        = $clog2(FIELD_CHARS + 1);
  localparam int VAL_W       = 16;
  localparam int FI_W        = 2;

  localparam logic [FI_W-1:0]  FIELD_LAST_IDX = FI_W'(3);
  localparam int               BURST_COUNT    = (PADS < MAX_OUT) ? PADS : MAX_OUT;
  localparam logic [PAD_W-1:0] LAST_BURST_PAD = PAD_W'(BURST_COUNT - 1);
  localparam logic [PAD_W-1:0] LAST_SCAN_PAD  = PAD_W'(PADS - 1);

  localparam logic [VAL_W-1:0] OFF_LIMIT_RST    = 16'd1000;
  localparam logic [VAL_W-1:0] RED_LIMIT_RST    = 16'd8000;
  localparam logic [VAL_W-1:0] GREEN_LIMIT_RST  = 16'd13000;
  localparam logic [VAL_W-1:0] REPORT_FLOOR_RST = 16'd2000;
  localparam logic [VAL_W-1:0] FULL_LEVEL_RST   = 16'd1023;

  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [1:0] {
    OP_SERIAL   = 2'd0,
    OP_PRESSURE = 2'd1,
    OP_LINK     = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    CFG_OFF_LIMIT    = 3'd0,
    CFG_RED_LIMIT    = 3'd1,
    CFG_GREEN_LIMIT  = 3'd2,
    CFG_REPORT_FLOOR = 3'd3,
    CFG_FULL_LEVEL   = 3'd4
  } cfg_e;

  localparam logic KIND_COLOR  = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  typedef struct packed {
    logic             valid;
    logic [PAD_W-1:0] pad;
    logic [VAL_W-1:0] red;
    logic [VAL_W-1:0] green;
    logic [VAL_W-1:0] blue;
  } pcp_rec_t;

  typedef struct packed {
    logic             kind;
    logic             burst;
    logic [PAD_W-1:0] pad;
    logic [VAL_W-1:0] red;
    logic [VAL_W-1:0] green;
    logic [VAL_W-1:0] blue;
    logic [VAL_W-1:0] pressure;
  } pcp_res_t;

  typedef struct packed {
    logic [1:0]       op;
    logic [7:0]       rx_byte;
    logic [VAL_W-1:0] sample;
    logic             link_up;
  } pcp_item_t;

  typedef struct packed {
    logic neg;
    logic started;
    logic stopped;
  } pcp_flags_t;

endpackage

[hdl/pcp_parser.sv]
// Serial record parser: decodes "pad,r,g,b" records one character per strobe.
// Depends on pcp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pcp_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              strobe_i,
  input  logic [7:0]        byte_i,
  input  logic              clear_i,
  output pcp_pkg::pcp_rec_t rec_o
);
  import pcp_pkg::*;

  logic [FI_W-1:0]  fi_q, fi_d;
  logic [CC_W-1:0]  cc_q, cc_d;
  logic [VAL_W-1:0] acc_q, acc_d;
  pcp_flags_t       flags_q, flags_d;
  logic [VAL_W-1:0] cap_q [3];
  logic [VAL_W-1:0] cap_d [3];

  logic             is_term, is_digit, is_blank, is_sign;
  logic [VAL_W-1:0] field_val, acc_next;

  assign is_term  = (byte_i == CH_COMMA) || (byte_i == CH_LF);
  assign is_digit = (byte_i >= CH_ZERO) && (byte_i <= CH_NINE);
  assign is_blank = (byte_i == CH_SPACE) || (byte_i == CH_TAB) || (byte_i == CH_VT) ||
                    (byte_i == CH_FF) || (byte_i == CH_CR);
  assign is_sign  = (byte_i == CH_PLUS) || (byte_i == CH_MINUS);
  assign field_val = flags_q.neg ? (VAL_W'(0) - acc_q) : acc_q;
  assign acc_next  = (acc_q << 3) + (acc_q << 1) + {{(VAL_W-4){1'b0}}, byte_i[3:0]};

  always_comb begin
    fi_d    = fi_q;
    cc_d    = cc_q;
    acc_d   = acc_q;
    flags_d = flags_q;
    cap_d   = cap_q;
    rec_o   = '0;
    if (strobe_i) begin
      if (is_term) begin
        cc_d    = '0;
        acc_d   = '0;
        flags_d = '0;
        if (fi_q != FIELD_LAST_IDX) begin
          cap_d[fi_q] = field_val;
          fi_d        = fi_q + FI_W'(1);
        end else begin
          fi_d      = '0;
          cap_d[0]  = '0;
          cap_d[1]  = '0;
          cap_d[2]  = '0;
          rec_o.valid = (cap_q[0] < VAL_W'(PADS));
          rec_o.pad   = cap_q[0][PAD_W-1:0];
          rec_o.red   = cap_q[1];
          rec_o.green = cap_q[2];
          rec_o.blue  = field_val;
        end
      end else if (cc_q == CC_W'(FIELD_CHARS)) begin
        // overlong field drops the record
        cc_d    = '0;
        acc_d   = '0;
        flags_d = '0;
        fi_d    = '0;
      end else begin
        cc_d = cc_q + CC_W'(1);
        priority if (flags_q.stopped) begin
        end else if (!flags_q.started) begin
          priority if (is_blank) begin
          end else if (is_sign) begin
            flags_d.started = 1'b1;
            flags_d.neg     = (byte_i == CH_MINUS);
          end else if (!is_digit) begin
            flags_d.stopped = 1'b1;
          end else begin
            flags_d.started = 1'b1;
            acc_d           = acc_next;
          end
        end else if (!is_digit) begin
          flags_d.stopped = 1'b1;
        end else begin
          acc_d = acc_next;
        end
      end
    end
    if (clear_i) begin
      fi_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fi_q    <= '0;
      cc_q    <= '0;
      acc_q   <= '0;
      flags_q <= '0;
      cap_q   <= '{default: '0};
    end else begin
      fi_q    <= fi_d;
      cc_q    <= cc_d;
      acc_q   <= acc_d;
      flags_q <= flags_d;
      cap_q   <= cap_d;
    end
  end

  `ASSERT_CLK(a_rec_after_three, rec_o.valid |-> (strobe_i && fi_q == FIELD_LAST_IDX), "record without three captured fields")
  `ASSERT_CLK(a_sign_only_started, flags_q.neg |-> flags_q.started, "sign flag set before start")
  `ASSERT_NEVER(a_cc_range, cc_q > CC_W'(FIELD_CHARS), "character count past field limit")

endmodule

[hdl/pad_color_command_parser.sv]
// Pad color command parser, top level: input register, item logic, result stage.
// Depends on pcp_pkg, pcp_parser and assert_macros.svh.
//
// One item is taken per cycle while the result register is free to accept: each is held in
// the input register, then decoded and applied to the state in a single pass into the result
// register, from which the result is presented. Items that give one result or none keep a
// one-per-cycle rate while the output is ready. A link-down item gives one color clear per
// pad, sent as a burst of four transfers from the result register, one per cycle while the
// output is ready; the input register holds the next item until the burst's final transfer
// is taken. Configuration writes are always ready and take effect next cycle.
`include "assert_macros.svh"

module pad_color_command_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  // tdata: rx_byte[7:0], sample[23:8], link_up[24], zero[31:25]
  input  logic [31:0] s_axis_tdata,
  // tuser: op[1:0]
  input  logic [1:0]  s_axis_tuser,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: pad[1:0], red[17:2], green[33:18], blue[49:34], pressure[65:50], zero[71:66]
  output logic [71:0] m_axis_tdata,
  // tuser: kind[0]
  output logic [0:0]  m_axis_tuser,
  output logic        m_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_addr_i,
  input  logic [15:0] cfg_data_i
);
  import pcp_pkg::*;

  logic [VAL_W-1:0] off_limit_q, red_limit_q, green_limit_q, report_floor_q, full_level_q;

  logic       in_valid_q;
  pcp_item_t  in_q;

  logic [PAD_W-1:0] scan_q, scan_d;
  logic             link_q, link_d;
  logic [VAL_W-1:0] last_q [PADS];

  logic     out_valid_q, out_valid_d;
  pcp_res_t res_q, res_d, res_new;
  logic     gen, out_last, out_free, advance;
  logic     sample_new, link_drop, parse_stb;
  pcp_rec_t rec;
  logic     res_dark, out_burst, out_report, in_stall;

  // configuration
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_limit_q    <= OFF_LIMIT_RST;
      red_limit_q    <= RED_LIMIT_RST;
      green_limit_q  <= GREEN_LIMIT_RST;
      report_floor_q <= REPORT_FLOOR_RST;
      full_level_q   <= FULL_LEVEL_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        CFG_OFF_LIMIT:    off_limit_q    <= cfg_data_i;
        CFG_RED_LIMIT:    red_limit_q    <= cfg_data_i;
        CFG_GREEN_LIMIT:  green_limit_q  <= cfg_data_i;
        CFG_REPORT_FLOOR: report_floor_q <= cfg_data_i;
        CFG_FULL_LEVEL:   full_level_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // handshake
  assign out_last      = !res_q.burst || (res_q.pad == LAST_BURST_PAD);
  assign out_free      = !out_valid_q || (m_axis_tready && out_last);
  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_q.op      <= s_axis_tuser;
      in_q.rx_byte <= s_axis_tdata[7:0];
      in_q.sample  <= s_axis_tdata[23:8];
      in_q.link_up <= s_axis_tdata[24];
    end
  end

  // item logic
  assign parse_stb  = advance && (in_q.op == OP_SERIAL);
  assign link_drop  = advance && (in_q.op == OP_LINK) && link_q && !in_q.link_up;
  assign sample_new = (last_q[scan_q] != in_q.sample);

  pcp_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .strobe_i (parse_stb),
    .byte_i   (in_q.rx_byte),
    .clear_i  (link_drop),
    .rec_o    (rec)
  );

  always_comb begin
    gen     = 1'b0;
    res_new = '0;
    scan_d  = scan_q;
    link_d  = link_q;
    unique case (in_q.op)
      OP_SERIAL: begin
        gen           = rec.valid;
        res_new.kind  = KIND_COLOR;
        res_new.pad   = rec.pad;
        res_new.red   = rec.red;
        res_new.green = rec.green;
        res_new.blue  = rec.blue;
      end
      OP_PRESSURE: begin
        scan_d      = (scan_q == LAST_SCAN_PAD) ? '0 : scan_q + PAD_W'(1);
        res_new.pad = scan_q;
        if (sample_new) begin
          if (!link_q) begin
            gen          = 1'b1;
            res_new.kind = KIND_COLOR;
            priority if (in_q.sample < off_limit_q) begin
            end else if (in_q.sample < red_limit_q) begin
              res_new.red = full_level_q;
            end else if (in_q.sample < green_limit_q) begin
              res_new.green = full_level_q;
            end else begin
              res_new.blue = full_level_q;
            end
          end else if (in_q.sample > report_floor_q) begin
            gen              = 1'b1;
            res_new.kind     = KIND_REPORT;
            res_new.pressure = in_q.sample;
          end
        end
      end
      OP_LINK: begin
        link_d        = in_q.link_up;
        gen           = link_q && !in_q.link_up;
        res_new.kind  = KIND_COLOR;
        res_new.burst = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q <= '0;
      link_q <= 1'b0;
      last_q <= '{default: '0};
    end else if (advance) begin
      scan_q <= scan_d;
      link_q <= link_d;
      if (in_q.op == OP_PRESSURE) begin
        last_q[scan_q] <= in_q.sample;
      end
    end
  end

  // result stage
  always_comb begin
    out_valid_d = out_valid_q;
    res_d       = res_q;
    if (out_valid_q && m_axis_tready) begin
      if (out_last) begin
        out_valid_d = 1'b0;
      end else begin
        res_d.pad = res_q.pad + PAD_W'(1);
      end
    end
    if (advance && gen) begin
      out_valid_d = 1'b1;
      res_d       = res_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tlast    = out_last;
  assign m_axis_tuser[0] = res_q.kind;
  assign m_axis_tdata    = {6'b0, res_q.pressure, res_q.blue, res_q.green, res_q.red,
                            res_q.pad};

  assign res_dark   = (res_q.red == '0) && (res_q.green == '0) && (res_q.blue == '0);
  assign out_burst  = m_axis_tvalid && res_q.burst;
  assign out_report = m_axis_tvalid && (res_q.kind == KIND_REPORT);
  assign in_stall   = in_valid_q && !advance;

  `ASSERT_CLK(a_multi_only_burst, (m_axis_tvalid && !m_axis_tlast) |-> res_q.burst, "bad tlast")
  `ASSERT_CLK(a_burst_zero, out_burst |-> (res_dark && res_q.kind == KIND_COLOR), "lit burst")
  `ASSERT_CLK(a_report_clean, out_report |-> (res_dark && !res_q.burst), "lit report")
  `ASSERT_CLK(a_hold_input, in_stall |=> (in_valid_q && $stable(in_q)), "input item lost")

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// Testbench for pad_color_command_parser: streams serial records, pressure samples and
// link events, tracks the pad state alongside and checks every result transfer.
// Depends on pcp_pkg and the parser RTL.
module tb;
  import pcp_pkg::*;

  localparam logic [1:0] OP_UNUSED     = 2'd3;
  localparam int         STALL_LIMIT   = 3000;
  localparam int         SETTLE_CYCLES = 8;
  localparam int         HOLD_CYCLES   = 200;
  localparam int         IDLE_PCT      = 38;

  typedef struct packed {
    logic        kind;
    logic [1:0]  pad;
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic [15:0] pressure;
    logic        last;
  } pad_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic [31:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_addr_i = '0;
  logic [15:0] cfg_data_i = '0;

  // tracked block state
  logic [15:0] lim_off, lim_red, lim_green, floor_rpt, level_full;
  logic [15:0] pad_red[PADS];
  logic [15:0] pad_green[PADS];
  logic [15:0] pad_blue[PADS];
  logic [15:0] seen_sample[PADS];
  logic [1:0]  scan_idx;
  logic        link_is_up;
  int          field_idx;
  int          char_cnt;
  logic [23:0] accum;
  logic        dec_neg, dec_started, dec_stopped;
  logic [15:0] captured[3];

  pad_result_t due_results[$];
  int          mismatch_count = 0;
  int          items_sent = 0;
  int          quiet_cycles = 0;
  int          hold_left = 0;
  bit          gaps_on = 1'b1;
  bit          steady = 1'b0;

  pad_color_command_parser u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- state tracker
  function automatic void reset_tracker();
    int i;
    lim_off    = OFF_LIMIT_RST;
    lim_red    = RED_LIMIT_RST;
    lim_green  = GREEN_LIMIT_RST;
    floor_rpt  = REPORT_FLOOR_RST;
    level_full = FULL_LEVEL_RST;
    for (i = 0; i < PADS; i++) begin
      pad_red[i]     = '0;
      pad_green[i]   = '0;
      pad_blue[i]    = '0;
      seen_sample[i] = '0;
    end
    for (i = 0; i < 3; i++) captured[i] = '0;
    scan_idx    = '0;
    link_is_up  = 1'b0;
    field_idx   = 0;
    char_cnt    = 0;
    accum       = '0;
    dec_neg     = 1'b0;
    dec_started = 1'b0;
    dec_stopped = 1'b0;
  endfunction

  function automatic void clear_decoder();
    char_cnt    = 0;
    accum       = '0;
    dec_neg     = 1'b0;
    dec_started = 1'b0;
    dec_stopped = 1'b0;
  endfunction

  function automatic void push_result(logic kind, logic [1:0] pad, logic [15:0] r,
                                      logic [15:0] g, logic [15:0] b, logic [15:0] p);
    pad_result_t res;
    res.kind     = kind;
    res.pad      = pad;
    res.red      = r;
    res.green    = g;
    res.blue     = b;
    res.pressure = p;
    res.last     = 1'b0;
    due_results.push_back(res);
  endfunction

  function automatic void store_color(logic [1:0] pad, logic [15:0] r, logic [15:0] g,
                                      logic [15:0] b);
    pad_red[pad]   = r;
    pad_green[pad] = g;
    pad_blue[pad]  = b;
    push_result(KIND_COLOR, pad, r, g, b, 16'd0);
  endfunction

  // atoi-style decode of one field character
  function automatic void decode_field_char(logic [7:0] c);
    logic is_digit;
    is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    if (dec_stopped) return;
    if (!dec_started) begin
      if (c == CH_SPACE || c == CH_TAB || c == CH_VT || c == CH_FF || c == CH_CR) return;
      if (c == CH_PLUS || c == CH_MINUS) begin
        if (c == CH_MINUS) dec_neg = 1'b1;
        dec_started = 1'b1;
        return;
      end
      if (!is_digit) begin
        dec_stopped = 1'b1;
        return;
      end
      dec_started = 1'b1;
    end else if (!is_digit) begin
      dec_stopped = 1'b1;
      return;
    end
    accum = 24'(accum * 10 + (c - CH_ZERO));
  endfunction

  function automatic void take_serial(logic [7:0] c);
    logic [15:0] v;
    int          i;
    if (c == CH_COMMA || c == CH_LF) begin
      v = dec_neg ? 16'(16'd0 - accum[15:0]) : accum[15:0];
      clear_decoder();
      if (field_idx < 3) begin
        captured[field_idx] = v;
        field_idx++;
      end else begin
        field_idx = 0;
        if (captured[0] < PADS) store_color(captured[0][1:0], captured[1], captured[2], v);
        for (i = 0; i < 3; i++) captured[i] = '0;
      end
    end else begin
      char_cnt++;
      if (char_cnt > FIELD_CHARS) begin
        clear_decoder();
        field_idx = 0;
      end else begin
        decode_field_char(c);
      end
    end
  endfunction

  function automatic void take_pressure(logic [15:0] s);
    logic [15:0] r, g, b;
    logic [1:0]  p;
    p = scan_idx;
    if (seen_sample[p] != s) begin
      seen_sample[p] = s;
      if (!link_is_up) begin
        r = '0;
        g = '0;
        b = '0;
        if (s >= lim_off) begin
          if (s < lim_red) r = level_full;
          else if (s < lim_green) g = level_full;
          else b = level_full;
        end
        store_color(p, r, g, b);
      end else if (s > floor_rpt) begin
        push_result(KIND_REPORT, p, 16'd0, 16'd0, 16'd0, s);
      end
    end
    scan_idx = (scan_idx == LAST_SCAN_PAD) ? '0 : scan_idx + 2'd1;
  endfunction

  function automatic void take_link(logic up);
    int i;
    if (link_is_up && !up) begin
      for (i = 0; i < PADS; i++) store_color(2'(i), 16'd0, 16'd0, 16'd0);
      field_idx = 0;
    end
    link_is_up = up;
  endfunction

  function automatic void update_pad_state(pcp_item_t it);
    int n_before;
    n_before = due_results.size();
    case (it.op)
      OP_SERIAL:   take_serial(it.rx_byte);
      OP_PRESSURE: take_pressure(it.sample);
      OP_LINK:     take_link(it.link_up);
      default: ;
    endcase
    if (due_results.size() > n_before) due_results[due_results.size() - 1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------- drivers
  task automatic send_item(input logic [1:0] op, input logic [7:0] rx,
                           input logic [15:0] smp, input logic up);
    pcp_item_t it;
    it.op      = op;
    it.rx_byte = rx;
    it.sample  = smp;
    it.link_up = up;
    while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tdata  = {7'd0, up, smp, rx};
    s_axis_tuser  = op;
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    update_pad_state(it);
    if (op != OP_UNUSED) items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_byte(input logic [7:0] c);
    send_item(OP_SERIAL, c, 16'($urandom), 1'($urandom));
  endtask

  task automatic send_text(input string txt);
    int i;
    for (i = 0; i < txt.len(); i++) send_byte(txt[i]);
  endtask

  task automatic send_sample(input logic [15:0] s);
    send_item(OP_PRESSURE, 8'($urandom), s, 1'($urandom));
  endtask

  task automatic send_link(input logic up);
    send_item(OP_LINK, 8'($urandom), 16'($urandom), up);
  endtask

  task automatic write_reg(input cfg_e idx, input logic [15:0] v);
    cfg_addr_i  = idx;
    cfg_data_i  = v;
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_OFF_LIMIT:    lim_off    = v;
      CFG_RED_LIMIT:    lim_red    = v;
      CFG_GREEN_LIMIT:  lim_green  = v;
      CFG_REPORT_FLOOR: floor_rpt  = v;
      CFG_FULL_LEVEL:   level_full = v;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic set_limits(input logic [15:0] off, input logic [15:0] red,
                            input logic [15:0] green, input logic [15:0] flr,
                            input logic [15:0] full);
    write_reg(CFG_OFF_LIMIT, off);
    write_reg(CFG_RED_LIMIT, red);
    write_reg(CFG_GREEN_LIMIT, green);
    write_reg(CFG_REPORT_FLOOR, flr);
    write_reg(CFG_FULL_LEVEL, full);
  endtask

  task automatic wait_idle();
    s_axis_tvalid = 1'b0;
    while (due_results.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  function automatic string random_record();
    string txt, pre, term;
    int    f, mag;
    txt = "";
    for (f = 0; f < 4; f++) begin
      case ($urandom_range(5))
        0:       pre = " ";
        1:       pre = "+";
        2:       pre = "-";
        3:       pre = "\t";
        default: pre = "";
      endcase
      if (f == 0)
        mag = ($urandom_range(9) == 0) ? $urandom_range(99999) : $urandom_range(PADS - 1);
      else
        mag = ($urandom_range(7) == 0) ? $urandom_range(9999999) : $urandom_range(65535);
      if (mag > 99999) pre = "";
      term = $urandom_range(1) ? "," : "\n";
      txt = {txt, pre, $sformatf("%0d", mag), term};
    end
    return txt;
  endfunction

  // ---------------------------------------------------------------- result side
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      m_axis_tready = 1'b0;
      hold_left     = hold_left - 1;
    end else begin
      m_axis_tready = steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  function automatic void report_mismatch(string what, pad_result_t want, pad_result_t got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t %s: expected kind=%0d pad=%0d rgb=%0d/%0d/%0d p=%0d last=%0d",
               $time, what, want.kind, want.pad, want.red, want.green, want.blue,
               want.pressure, want.last);
      $display("  got kind=%0d pad=%0d rgb=%0d/%0d/%0d p=%0d last=%0d",
               got.kind, got.pad, got.red, got.green, got.blue, got.pressure, got.last);
    end
  endfunction

  always @(posedge clk_i) begin : check_results
    pad_result_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.kind     = m_axis_tuser[0];
      got.pad      = m_axis_tdata[1:0];
      got.red      = m_axis_tdata[17:2];
      got.green    = m_axis_tdata[33:18];
      got.blue     = m_axis_tdata[49:34];
      got.pressure = m_axis_tdata[65:50];
      got.last     = m_axis_tlast;
      if (due_results.size() == 0) begin
        report_mismatch("unexpected transfer", '0, got);
      end else begin
        want = due_results.pop_front();
        if (got !== want) report_mismatch("result mismatch", want, got);
      end
    end
  end

  // ---------------------------------------------------------------- watchdog
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= STALL_LIMIT);
    $display("pad_color_command_parser verification failed");
    $finish;
  end

  // ---------------------------------------------------------------- tests
  task automatic test_color_records();
    send_text("0,1,2,3\n");
    send_text("3,65535,-1,+7,");
    wait_idle();
  endtask

  task automatic test_field_corners();
    send_text("12345678,1,2,3\n");       // overlong field drops the record
    send_text("9,1,2,3\n");              // pad out of range
    send_text("-1,4,5,6\n");             // negative pad
    send_text(" 2,\t-0,7");
    send_byte(8'h00);                    // NUL stops the field
    send_text("9,++5\n");
    send_text("1,1234567,70000,-65536\n");
    wait_idle();
  endtask

  task automatic test_thresholds();
    send_sample(16'd0);                  // same as last sample
    send_sample(16'd999);
    send_sample(16'd1000);
    send_sample(16'd7999);
    send_sample(16'd8000);
    send_sample(16'd12999);
    send_sample(16'd13000);
    send_sample(16'd65535);
    wait_idle();
  endtask

  task automatic test_link_events();
    send_link(1'b1);
    send_sample(16'd2000);
    send_sample(16'd2001);
    send_sample(16'd2001);
    send_sample(16'd65535);
    send_item(OP_UNUSED, 8'hFF, 16'hFFFF, 1'b0);
    send_link(1'b1);
    send_text("1,");
    send_link(1'b0);                     // clears all pads
    send_link(1'b0);
    send_text("2,3,4\n");
    wait_idle();
  endtask

  task automatic test_backpressure();
    int k;
    gaps_on   = 1'b0;
    hold_left = HOLD_CYCLES;
    for (k = 0; k < 4; k++) begin
      send_link(1'b1);
      send_link(1'b0);
    end
    for (k = 0; k < 2; k++) send_text(random_record());
    gaps_on = 1'b1;
    wait_idle();
  endtask

  task automatic test_random_traffic(input int n);
    int          target, pick;
    logic [15:0] base;
    target = items_sent + n;
    while (items_sent < target) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        send_text(random_record());
      end else if (pick < 80) begin
        case ($urandom_range(3))
          0: send_sample(seen_sample[scan_idx]);
          1: begin
            case ($urandom_range(3))
              0:       base = lim_off;
              1:       base = lim_red;
              2:       base = lim_green;
              default: base = floor_rpt;
            endcase
            send_sample(16'(base + $urandom_range(2) - 1));
          end
          default: send_sample(16'($urandom));
        endcase
      end else if (pick < 86) begin
        send_link(1'($urandom));
      end else if (pick < 93) begin
        send_byte(8'($urandom_range(255)));
      end else if (pick < 96) begin
        send_text("123456789");
      end else begin
        send_item(OP_UNUSED, 8'($urandom), 16'($urandom), 1'($urandom));
      end
    end
    wait_idle();
  endtask

  task automatic test_limit_extremes();
    set_limits(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    test_random_traffic(8);
    set_limits(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    test_random_traffic(8);
  endtask

  task automatic test_random_limits();
    logic [15:0] off, red, green;
    set_limits(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    test_random_traffic(10);
    off   = 16'($urandom_range(4000));
    red   = off + 16'($urandom_range(8000));
    green = red + 16'($urandom_range(8000));
    set_limits(off, red, green, 16'($urandom_range(6000)), 16'($urandom));
    test_random_traffic(10);
  endtask

  task automatic test_steady_stream();
    steady  = 1'b1;
    gaps_on = 1'b0;
    test_random_traffic(16);
    steady  = 1'b0;
    gaps_on = 1'b1;
  endtask

  initial begin
    reset_tracker();
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_color_records();
    test_field_corners();
    test_thresholds();
    test_link_events();
    test_backpressure();
    test_limit_extremes();
    test_random_limits();
    test_steady_stream();
    set_limits(OFF_LIMIT_RST, RED_LIMIT_RST, GREEN_LIMIT_RST, REPORT_FLOOR_RST,
               FULL_LEVEL_RST);
    test_random_traffic(6);
    wait_idle();
    if (mismatch_count == 0) begin
      $display("pad_color_command_parser verification clean");
    end else begin
      $display("pad_color_command_parser verification failed");
    end
    $finish;
  end

endmodule

[pad_color_command_parser.f]
+incdir+hdl
hdl/pcp_pkg.sv
hdl/pcp_parser.sv
hdl/pad_color_command_parser.sv
tb/sv/tb.sv
